@@ design/cbte_pkg.sv @@
// shared types and constants of the cell block truncation encoder
package cbte_pkg;

  localparam int LUMA_IDX_W   = 16;
  localparam int CHROMA_IDX_W = 12;
  localparam int CODE_BYTE_W  = 8;
  localparam int PIX_W        = 8;
  localparam int NUM_PIX      = 16;
  localparam int SUM_W        = 12;
  localparam int DSR_W        = 5;
  localparam int QUO_W        = 8;

  localparam logic [7:0] SKIP_FLAG = 8'h80;

  typedef enum logic [1:0] {
    FUNC_ENCODE    = 2'd0,
    FUNC_LUMA_WR   = 2'd1,
    FUNC_CHROMA_WR = 2'd2
  } func_e;

  typedef struct packed {
    func_e        func;
    logic         frame_start;
    logic         cell_changed;
    logic [63:0]  luma_rows_upper;
    logic [63:0]  luma_rows_lower;
    logic [7:0]   chroma_u;
    logic [7:0]   chroma_v;
    logic [15:0]  table_index;
    logic [7:0]   table_value;
  } cbte_in_t;

  typedef struct packed {
    logic         is_cell_word;
    logic [31:0]  code;
    logic         last_of_run;
  } cbte_out_t;

  // request to the divider
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

endpackage

@@ design/cbte_ram.sv @@
// generic simple dual port ram with registered read
module cbte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cbte_div.sv @@
// restoring divider, one quotient bit per cycle, quotient known to fit in eight bits
module cbte_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cbte_pkg::div_req_t          req_i,
  output logic                        idle_o,
  output logic [cbte_pkg::QUO_W-1:0]  quotient_o
);
  import cbte_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [STEP_W-1:0] step_q, step_d;
  logic [DSR_W-1:0]  rem_q, rem_d;
  logic [DSR_W-1:0]  dsr_q, dsr_d;
  logic [QUO_W-1:0]  dvd_q, dvd_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DSR_W:0]    rem_sh;
  logic [DSR_W:0]    rem_diff;
  logic              qbit;

  always_comb begin
    rem_sh   = {rem_q, dvd_q[QUO_W-1]};
    rem_diff = rem_sh - {1'b0, dsr_q};
    qbit     = (rem_sh >= {1'b0, dsr_q});
    step_d   = step_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    if (req_i.start) begin
      // upper dividend bits lie below the divisor, so only eight steps remain
      step_d = STEP_W'(QUO_W);
      rem_d  = DSR_W'(req_i.dividend[SUM_W-1:QUO_W]);
      dsr_d  = req_i.divisor;
      dvd_d  = req_i.dividend[QUO_W-1:0];
      quo_d  = '0;
    end else if (step_q != '0) begin
      step_d = step_q - STEP_W'(1);
      rem_d  = qbit ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      dvd_d  = {dvd_q[QUO_W-2:0], 1'b0};
      quo_d  = {quo_q[QUO_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign idle_o     = (step_q == '0);
  assign quotient_o = quo_q;

  // a start always begins a full run of steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> step_q == STEP_W'(QUO_W))
    else $error("divider did not load step count");

  // the step count only falls while a run is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.start && step_q != '0 |=> step_q == $past(step_q) - STEP_W'(1))
    else $error("divider step count skipped");

  // the remainder stays below the divisor while a run is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 && dsr_q != '0 |-> rem_q < dsr_q)
    else $error("divider remainder out of range");

endmodule

@@ design/cell_block_truncation_encoder_unit.sv @@
// top level of the cell block truncation encoder
//
// Takes one word per 4x4 cell: table loads, unused function codes and skipped cells that do
// not close a run finish in the cycle they are accepted; a skipped cell that brings the run to
// SKIP_RUN_MAX goes on to S_SKIP to issue its skip byte. A changed cell passes through S_SUM
// (sum), S_MASK (mask), S_DIV (the two parallel eight step dividers that form the low and
// high means; the registered table reads are issued as both finish) and S_CELL (to issue its
// cell word into the output register), with S_SKIP ahead of S_SUM when a pending skip byte
// goes out first. A word waits in S_SKIP or S_CELL as long as the output register is full.
// The luma pair table (65536 x 8) and the chroma table (4096 x 8) are
// synchronous memories loaded through the input channel; they need no clearing after reset,
// and reading an entry never written returns an arbitrary byte. An output register parts the
// two channels, so the next word is taken while a result still waits for out_ready_i. Skip
// runs are counted and sent as 0x80|(run-1) ahead of the next coded cell or when the run
// reaches SKIP_RUN_MAX; a frame start drops any run still pending.
module cell_block_truncation_encoder_unit #(
  parameter int SKIP_RUN_MAX = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cbte_pkg::cbte_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cbte_pkg::cbte_out_t out_data_o
);
  import cbte_pkg::*;

  localparam int CntW = $clog2(SKIP_RUN_MAX);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SKIP = 6'b000010,
    S_SUM  = 6'b000100,
    S_MASK = 6'b001000,
    S_DIV  = 6'b010000,
    S_CELL = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // control
  logic            in_acc;
  logic            out_free;
  logic            out_push;
  cbte_out_t       out_word;
  logic [CntW-1:0] skip_q, skip_d;
  logic [CntW-1:0] skip_eff;
  logic [CntW:0]   skip_inc;
  logic            long_run;
  logic            cell_pend_q, cell_pend_d;
  logic [CntW-1:0] skip_code_q, skip_code_d;
  logic            out_valid_q;
  cbte_out_t       out_q;

  // cell payload
  cbte_in_t        cell_q;
  logic [PIX_W-1:0] pix [NUM_PIX];
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_tree;
  logic [NUM_PIX-1:0] mask_q, mask_c;
  logic             lo_zero_q;
  logic [PIX_W-1:0] mean;
  logic [SUM_W-1:0] lo_sum;
  logic [DSR_W-1:0] n_low;
  logic [PIX_W:0]   s1 [8];
  logic [PIX_W+1:0] s2 [4];
  logic [PIX_W+2:0] s3 [2];
  logic [PIX_W:0]   l1 [8];
  logic [PIX_W+1:0] l2 [4];
  logic [PIX_W+2:0] l3 [2];
  logic [PIX_W-1:0] lo_val [NUM_PIX];

  // dividers and tables
  div_req_t             hi_req, lo_req;
  logic                 hi_idle, lo_idle;
  logic [QUO_W-1:0]     hi_quo, lo_quo, lo_mean;
  logic                 tbl_re;
  logic [LUMA_IDX_W-1:0]   luma_idx;
  logic [CHROMA_IDX_W-1:0] chroma_idx;
  logic [CODE_BYTE_W-1:0]  luma_byte, chroma_byte;
  logic                 luma_we, chroma_we;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // skip run bookkeeping at accept
  assign skip_eff = in_data_i.frame_start ? '0 : skip_q;
  assign skip_inc = {1'b0, skip_eff} + (CntW+1)'(1);
  assign long_run = (skip_inc == (CntW+1)'(SKIP_RUN_MAX));

  // table loads go straight from the input word
  assign luma_we   = in_acc && (in_data_i.func == FUNC_LUMA_WR);
  assign chroma_we = in_acc && (in_data_i.func == FUNC_CHROMA_WR);

  // pixel unpacking, raster order, first pixel in the top byte
  always_comb begin
    for (int i = 0; i < NUM_PIX/2; i++) begin
      pix[i]             = cell_q.luma_rows_upper[63-8*i -: 8];
      pix[i+NUM_PIX/2]   = cell_q.luma_rows_lower[63-8*i -: 8];
    end
  end

  // sum of all pixels as a balanced tree
  always_comb begin
    for (int j = 0; j < 8; j++) s1[j] = {1'b0, pix[2*j]} + {1'b0, pix[2*j+1]};
    for (int j = 0; j < 4; j++) s2[j] = {1'b0, s1[2*j]} + {1'b0, s1[2*j+1]};
    for (int j = 0; j < 2; j++) s3[j] = {1'b0, s2[2*j]} + {1'b0, s2[2*j+1]};
    sum_tree = {1'b0, s3[0]} + {1'b0, s3[1]};
  end

  // mask of pixels below the mean and their sum
  assign mean = sum_q[SUM_W-1:4];
  always_comb begin
    for (int i = 0; i < NUM_PIX; i++) begin
      mask_c[NUM_PIX-1-i] = (pix[i] < mean);
      lo_val[i]           = (pix[i] < mean) ? pix[i] : '0;
    end
    for (int j = 0; j < 8; j++) l1[j] = {1'b0, lo_val[2*j]} + {1'b0, lo_val[2*j+1]};
    for (int j = 0; j < 4; j++) l2[j] = {1'b0, l1[2*j]} + {1'b0, l1[2*j+1]};
    for (int j = 0; j < 2; j++) l3[j] = {1'b0, l2[2*j]} + {1'b0, l2[2*j+1]};
    lo_sum = {1'b0, l3[0]} + {1'b0, l3[1]};
    n_low  = DSR_W'($countones(mask_c));
  end

  // hi mean over the pixels at or above the mean, lo mean over the rest
  always_comb begin
    hi_req.start    = (state_q == S_MASK);
    hi_req.dividend = sum_q - lo_sum;
    hi_req.divisor  = DSR_W'(NUM_PIX) - n_low;
    lo_req.start    = (state_q == S_MASK);
    lo_req.dividend = lo_sum;
    lo_req.divisor  = n_low;
  end

  cbte_div u_div_hi (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (hi_req),
    .idle_o     (hi_idle),
    .quotient_o (hi_quo)
  );

  cbte_div u_div_lo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (lo_req),
    .idle_o     (lo_idle),
    .quotient_o (lo_quo)
  );

  // pair index swaps when the first pixel is a low pixel
  assign lo_mean    = lo_zero_q ? '0 : lo_quo;
  assign luma_idx   = mask_q[NUM_PIX-1] ? {lo_mean, hi_quo} : {hi_quo, lo_mean};
  assign chroma_idx = {cell_q.chroma_u[7:2], cell_q.chroma_v[7:2]};
  assign tbl_re     = (state_q == S_DIV) && hi_idle && lo_idle;

  cbte_ram #(
    .WIDTH (CODE_BYTE_W),
    .DEPTH (1 << LUMA_IDX_W)
  ) u_luma_tbl (
    .clk_i   (clk_i),
    .we_i    (luma_we),
    .waddr_i (in_data_i.table_index),
    .wdata_i (in_data_i.table_value),
    .re_i    (tbl_re),
    .raddr_i (luma_idx),
    .rdata_o (luma_byte)
  );

  cbte_ram #(
    .WIDTH (CODE_BYTE_W),
    .DEPTH (1 << CHROMA_IDX_W)
  ) u_chroma_tbl (
    .clk_i   (clk_i),
    .we_i    (chroma_we),
    .waddr_i (in_data_i.table_index[CHROMA_IDX_W-1:0]),
    .wdata_i (in_data_i.table_value),
    .re_i    (tbl_re),
    .raddr_i (chroma_idx),
    .rdata_o (chroma_byte)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    skip_d      = skip_q;
    cell_pend_d = cell_pend_q;
    skip_code_d = skip_code_q;
    out_push    = 1'b0;
    out_word    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.func == FUNC_ENCODE) begin
          if (in_data_i.cell_changed) begin
            skip_d      = '0;
            cell_pend_d = 1'b1;
            skip_code_d = skip_eff - CntW'(1);
            state_d     = (skip_eff != '0) ? S_SKIP : S_SUM;
          end else if (long_run) begin
            skip_d      = '0;
            cell_pend_d = 1'b0;
            skip_code_d = CntW'(SKIP_RUN_MAX - 1);
            state_d     = S_SKIP;
          end else begin
            skip_d = skip_inc[CntW-1:0];
          end
        end
      end
      S_SKIP: begin
        out_word.is_cell_word = 1'b0;
        out_word.code         = {24'h0, SKIP_FLAG | 8'(skip_code_q)};
        out_word.last_of_run  = !cell_pend_q;
        if (out_free) begin
          out_push = 1'b1;
          state_d  = cell_pend_q ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        state_d = S_MASK;
      end
      S_MASK: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (hi_idle && lo_idle) begin
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        out_word.is_cell_word = 1'b1;
        out_word.code = {(mask_q[NUM_PIX-1] ? ~mask_q : mask_q), chroma_byte, luma_byte};
        out_word.last_of_run  = 1'b1;
        if (out_free) begin
          out_push    = 1'b1;
          cell_pend_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      skip_q      <= '0;
      cell_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      skip_q      <= skip_d;
      cell_pend_q <= cell_pend_d;
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    skip_code_q <= skip_code_d;
    if (in_acc) begin
      cell_q <= in_data_i;
    end
    if (state_q == S_SUM) begin
      sum_q <= sum_tree;
    end
    if (state_q == S_MASK) begin
      mask_q    <= mask_c;
      lo_zero_q <= (n_low == '0);
    end
    if (out_push) begin
      out_q <= out_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the pending run stays below the long run limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q < CntW'(SKIP_RUN_MAX - 1) || skip_q == CntW'(SKIP_RUN_MAX - 1))
    else $error("skip count reached run limit");

  // an accepted changed cell always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.func == FUNC_ENCODE && in_data_i.cell_changed
    |=> state_q == S_SKIP || state_q == S_SUM)
    else $error("changed cell not started");

  // a skip byte that is not last is followed by its cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push && !out_word.is_cell_word && !out_word.last_of_run |=> state_q == S_SUM)
    else $error("cell lost after pending skip byte");

  // both dividers run in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> hi_idle == lo_idle)
    else $error("dividers out of step");

  // a word is only pushed when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_valid_q || out_ready_i)
    else $error("output register overwritten");

endmodule
